// File: rtl/icc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and kernel tables of the window convolution unit.
// Used by the top level, icc_front, icc_back and icc_queue; depends on nothing.
package icc_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 2048;
  localparam int NUM_ROWS     = 9;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);
  localparam int DIM_W        = 12;
  localparam int SLOT_W       = $clog2(NUM_ROWS);
  localparam int SUM_W        = 17;
  localparam int QDEPTH       = 8;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int PIX_W        = 24;

  // configuration register indexes
  localparam logic [1:0] CFG_KERNEL = 2'd0;
  localparam logic [1:0] CFG_GRAY   = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  // kernel codes
  localparam logic [1:0] KS_CONTRAST = 2'd0;
  localparam logic [1:0] KS_SOBEL_X  = 2'd1;
  localparam logic [1:0] KS_SOBEL_Y  = 2'd2;

  typedef logic signed [5:0] weight_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [1:0] ks;
    logic       gray;
  } win_ctrl_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic       last;
  } result_t;

  localparam int K9 [9][9] = '{
    '{ 0, 0, 0,-1,-1,-1, 0, 0, 0},
    '{ 0,-2,-3,-3,-3,-3,-3,-2, 0},
    '{ 0,-3,-2,-1,-1,-1,-2,-3, 0},
    '{-1,-3,-1, 9, 9, 9,-1,-3,-1},
    '{-1,-3,-1, 9,19, 9,-1,-3,-1},
    '{-1,-3,-1, 9, 9, 9,-1,-3,-1},
    '{ 0,-3,-2,-1,-1,-1,-2,-3, 0},
    '{ 0,-2,-3,-3,-3,-3,-3,-2, 0},
    '{ 0, 0, 0,-1,-1,-1, 0, 0, 0}
  };
  localparam int KSX [3][3] = '{'{-1, 0, 1}, '{-2, 0, 2}, '{-1, 0, 1}};
  localparam int KSY [3][3] = '{'{ 1, 2, 1}, '{ 0, 0, 0}, '{-1,-2,-1}};

  // Weight of window tap (r,c); 3x3 kernels sit in the bottom-right corner.
  function automatic weight_t tap_weight(logic [1:0] ks, int r, int c);
    weight_t w;
    w = '0;
    if (ks == KS_CONTRAST) begin
      w = weight_t'(K9[r][c]);
    end else if (r >= NUM_ROWS - 3 && c >= NUM_ROWS - 3) begin
      if (ks == KS_SOBEL_X) w = weight_t'(KSX[r-NUM_ROWS+3][c-NUM_ROWS+3]);
      else                  w = weight_t'(KSY[r-NUM_ROWS+3][c-NUM_ROWS+3]);
    end
    return w;
  endfunction

  // floor((r+g+b)/3) by reciprocal multiply, exact for sums up to 765
  function automatic logic [7:0] gray_of(pixel_t p);
    logic [9:0]  s;
    logic [19:0] m;
    s = 10'(p.r) + 10'(p.g) + 10'(p.b);
    m = 20'(s) * 20'd683;
    return m[18:11];
  endfunction

endpackage

// File: rtl/image_window_convolution_clamp_unit.sv
`timescale 1ns / 1ps
// Top level of the 3x3 / 9x9 window convolution unit with byte clamp.
// Depends on icc_pkg, icc_front, icc_back and icc_queue.
//
// Usage: RGB pixels enter in raster order on the in channel (in_valid_i /
// in_stall_o), one transfer per clock when not stalled. Each pixel that
// completes a window produces one result on the out channel (out_valid_o /
// out_stall_i): three clamped channels and frame_end_o on the last result
// of a frame. Pixels near the top and left edge and in the last row and
// column give no result.
// Each result passes these registers in order: position and line-store read,
// window shift, row sums, totals, queue.
// Throughput: one pixel per clock while in_stall_o is low, with one line-store
// read per row slot per pixel.
// An 8-entry result queue holds a slot for every result in flight; when the
// receiver stalls and all slots are held, in_stall_o rises until a result
// is taken. Reset clears counters and the queue and loads the default
// configuration (Sobel-x, colour, 640x480); the line store is not cleared.
// Configuration writes on cfg_we_i take effect on the next pixel.
module image_window_convolution_clamp_unit import icc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  chan_a_out_o,
  output logic [7:0]  chan_b_out_o,
  output logic [7:0]  chan_c_out_o,
  output logic        frame_end_o
);

  logic       reserve, res_valid;
  pixel_t     win  [NUM_ROWS][NUM_ROWS];
  logic [7:0] gwin [NUM_ROWS][NUM_ROWS];
  win_ctrl_t  ctrl;
  result_t    res, head;

  icc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .stall_i     (in_stall_o),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .reserve_o   (reserve),
    .win_o       (win),
    .gwin_o      (gwin),
    .ctrl_o      (ctrl)
  );

  icc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_i       (win),
    .gwin_i      (gwin),
    .ctrl_i      (ctrl),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  icc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (reserve),
    .wr_valid_i  (res_valid),
    .wr_data_i   (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (head),
    .stall_o     (in_stall_o)
  );

  assign chan_a_out_o = head.a;
  assign chan_b_out_o = head.b;
  assign chan_c_out_o = head.c;
  assign frame_end_o  = head.last;

endmodule

// File: rtl/icc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module icc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/icc_front.sv
`timescale 1ns / 1ps
// Front end: config registers, raster position tracking, line store and window.
// Depends on icc_pkg and icc_ram.
module icc_front import icc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        stall_i,
  input  logic [7:0]  red_in_i,
  input  logic [7:0]  green_in_i,
  input  logic [7:0]  blue_in_i,
  output logic        reserve_o,
  output pixel_t      win_o  [NUM_ROWS][NUM_ROWS],
  output logic [7:0]  gwin_o [NUM_ROWS][NUM_ROWS],
  output win_ctrl_t   ctrl_o
);

  logic [1:0]       ks_q;
  logic             gray_q;
  logic [DIM_W-1:0] fw_q, fh_q;
  logic [ADDR_W-1:0] col_q, row_q, col_d, row_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              accept;
  logic [1:0]        ks_eff;
  logic [DIM_W-1:0]  wd, hd, km1;
  logic [DIM_W-1:0]  c0, r0, c1, r1;
  logic [SLOT_W-1:0] s0, s1;
  logic              emit, last;
  pixel_t            pix;

  // stage 1 (RAM read data returns)
  logic              v1_q;
  pixel_t            pix1_q;
  logic [SLOT_W-1:0] slot1_q;
  win_ctrl_t         ctrl1_q, ctrl2_q;
  logic [PIX_W-1:0]  rd [NUM_ROWS];
  pixel_t            col_vec [NUM_ROWS];

  pixel_t     win_q  [NUM_ROWS][NUM_ROWS];
  logic [7:0] gwin_q [NUM_ROWS][NUM_ROWS];

  assign accept = in_valid_i && !stall_i;
  assign pix    = '{b: blue_in_i, g: green_in_i, r: red_in_i};

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q   <= KS_SOBEL_X;
      gray_q <= 1'b0;
      fw_q   <= DIM_W'(640);
      fh_q   <= DIM_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KERNEL: ks_q   <= cfg_data_i[1:0];
        CFG_GRAY:   gray_q <= cfg_data_i[0];
        CFG_WIDTH:  fw_q   <= cfg_data_i;
        CFG_HEIGHT: fh_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective sizes and kernel
  always_comb begin
    ks_eff = (ks_q > KS_SOBEL_Y) ? KS_SOBEL_Y : ks_q;
    km1    = (ks_eff == KS_CONTRAST) ? DIM_W'(NUM_ROWS - 1) : DIM_W'(2);
    if (fw_q == '0)                     wd = DIM_W'(1);
    else if (fw_q > DIM_W'(MAX_WIDTH))  wd = DIM_W'(MAX_WIDTH);
    else                                wd = fw_q;
    if (fh_q == '0)                       hd = DIM_W'(1);
    else if (fh_q > DIM_W'(HEIGHT_LIMIT)) hd = DIM_W'(HEIGHT_LIMIT);
    else                                  hd = fh_q;
  end

  // position of this pixel, and of the next one
  always_comb begin
    c0 = DIM_W'(col_q);
    r0 = DIM_W'(row_q);
    s0 = slot_q;
    if (c0 >= wd) begin
      c0 = '0;
      r0 = r0 + DIM_W'(1);
      s0 = (s0 == SLOT_W'(NUM_ROWS - 1)) ? '0 : s0 + SLOT_W'(1);
    end
    if (r0 >= hd) begin
      r0 = '0;
      s0 = '0;
    end
    c1 = c0 + DIM_W'(1);
    r1 = r0;
    s1 = s0;
    if (c1 >= wd) begin
      c1 = '0;
      r1 = r0 + DIM_W'(1);
      s1 = (s0 == SLOT_W'(NUM_ROWS - 1)) ? '0 : s0 + SLOT_W'(1);
      if (r1 >= hd) begin
        r1 = '0;
        s1 = '0;
      end
    end
    col_d  = c1[ADDR_W-1:0];
    row_d  = r1[ADDR_W-1:0];
    slot_d = s1;
    emit = (r0 >= km1) && (c0 >= km1) && (r0 + DIM_W'(1) < hd) && (c0 + DIM_W'(1) < wd);
    last = (r0 + DIM_W'(2) == hd) && (c0 + DIM_W'(2) == wd);
  end

  assign reserve_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (accept) begin
      col_q  <= col_d;
      row_q  <= row_d;
      slot_q <= slot_d;
    end
  end

  // line store: one RAM per row slot, written at the current slot only
  for (genvar s = 0; s < NUM_ROWS; s++) begin : g_line
    icc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept && (s0 == SLOT_W'(s))),
      .waddr_i (c0[ADDR_W-1:0]),
      .wdata_i (pix),
      .re_i    (accept),
      .raddr_i (c0[ADDR_W-1:0]),
      .rdata_o (rd[s])
    );
  end

  // stage 1 control, and its delayed copy that goes with the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      ctrl1_q <= '0;
      ctrl2_q <= '0;
    end else begin
      v1_q    <= accept;
      ctrl1_q <= '{valid: accept && emit, last: last, ks: ks_eff, gray: gray_q};
      ctrl2_q <= ctrl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q  <= pix;
      slot1_q <= s0;
    end
  end

  // column entering the window: oldest row on top, current pixel at the bottom
  always_comb begin
    logic [SLOT_W:0] idx;
    for (int i = 0; i < NUM_ROWS - 1; i++) begin
      idx = (SLOT_W+1)'(slot1_q) + (SLOT_W+1)'(i + 1);
      if (idx >= (SLOT_W+1)'(NUM_ROWS)) idx = idx - (SLOT_W+1)'(NUM_ROWS);
      col_vec[i] = pixel_t'(rd[idx[SLOT_W-1:0]]);
    end
    col_vec[NUM_ROWS-1] = pix1_q;
  end

  // window shift, raw pixels and their gray values
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        for (int c = 0; c < NUM_ROWS - 1; c++) begin
          win_q[r][c]  <= win_q[r][c+1];
          gwin_q[r][c] <= gwin_q[r][c+1];
        end
        win_q[r][NUM_ROWS-1]  <= col_vec[r];
        gwin_q[r][NUM_ROWS-1] <= gray_of(col_vec[r]);
      end
    end
  end

  assign win_o  = win_q;
  assign gwin_o = gwin_q;
  assign ctrl_o = ctrl2_q;

endmodule

// File: rtl/icc_back.sv
`timescale 1ns / 1ps
// Back end: weighted row sums, column total and clamp of the three channels.
// Depends on icc_pkg.
module icc_back import icc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pixel_t     win_i  [NUM_ROWS][NUM_ROWS],
  input  logic [7:0] gwin_i [NUM_ROWS][NUM_ROWS],
  input  win_ctrl_t  ctrl_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic signed [SUM_W-1:0] rs_d [3][NUM_ROWS];
  logic signed [SUM_W-1:0] rs_q [3][NUM_ROWS];
  logic signed [SUM_W-1:0] tot_d [3];
  logic signed [SUM_W-1:0] tot_q [3];
  logic [7:0]              clip [3];
  win_ctrl_t               ctrl_a_q, ctrl_b_q;

  // per-row weighted sums
  always_comb begin
    logic [7:0]              v;
    logic signed [SUM_W-1:0] vx, wx, acc;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        acc = '0;
        for (int c = 0; c < NUM_ROWS; c++) begin
          if (ch == 0)      v = ctrl_i.gray ? gwin_i[r][c] : win_i[r][c].r;
          else if (ch == 1) v = win_i[r][c].g;
          else              v = win_i[r][c].b;
          vx  = SUM_W'(v);
          wx  = SUM_W'(tap_weight(ctrl_i.ks, r, c));
          acc = acc + vx * wx;
        end
        rs_d[ch][r] = acc;
      end
    end
  end

  // totals over rows
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot_d[ch] = '0;
      for (int r = 0; r < NUM_ROWS; r++) tot_d[ch] = tot_d[ch] + rs_q[ch][r];
    end
  end

  always_ff @(posedge clk_i) begin
    rs_q  <= rs_d;
    tot_q <= tot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
      ctrl_b_q <= '0;
    end else begin
      ctrl_a_q <= ctrl_i;
      ctrl_b_q <= ctrl_a_q;
    end
  end

  // clamp to a byte
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (tot_q[ch] < 0)                   clip[ch] = 8'd0;
      else if (tot_q[ch] > SUM_W'(255))    clip[ch] = 8'd255;
      else                                 clip[ch] = tot_q[ch][7:0];
    end
  end

  assign res_valid_o = ctrl_b_q.valid;
  assign res_o = '{a:    clip[0],
                   b:    ctrl_b_q.gray ? 8'd0 : clip[1],
                   c:    ctrl_b_q.gray ? 8'd0 : clip[2],
                   last: ctrl_b_q.last};

endmodule

// File: rtl/icc_queue.sv
`timescale 1ns / 1ps
// Result queue with slot reservation, so the pipeline never has to stall.
// Depends on icc_pkg.
module icc_queue import icc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    reserve_i,
  input  logic    wr_valid_i,
  input  result_t wr_data_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t out_data_o,
  output logic    stall_o
);

  result_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q, rsv_q;
  logic              pop;

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // a slot is held from accept until the result transfers out
  assign stall_o     = rsv_q == (QPTR_W+1)'(QDEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      rsv_q    <= '0;
    end else begin
      if (wr_valid_i) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop)        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      cnt_q <= cnt_q + (QPTR_W+1)'(wr_valid_i) - (QPTR_W+1)'(pop);
      rsv_q <= rsv_q + (QPTR_W+1)'(reserve_i) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// File: rtl/icc_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the convolution unit, bound to the top level.
// Depends on the top-level port list only.
module icc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] chan_a_out_o,
  input logic [7:0] chan_b_out_o,
  input logic [7:0] chan_c_out_o,
  input logic       frame_end_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(chan_a_out_o) && $stable(chan_b_out_o) &&
      $stable(chan_c_out_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // input is only held off while results are backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty queue");

  // a result appearing on an empty output came from an earlier pixel transfer
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 5))
    else $error("result without matching pixel transfer");

endmodule

bind image_window_convolution_clamp_unit icc_checker u_icc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .chan_a_out_o (chan_a_out_o),
  .chan_b_out_o (chan_b_out_o),
  .chan_c_out_o (chan_c_out_o),
  .frame_end_o  (frame_end_o)
);
